[sv/rrjs_pkg.sv]
// shared types, constants and register map of the round-robin job scheduler
package rrjs_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned TIME_WIDTH_DEF  = 16;

	localparam logic       POLICY_RESET  = 1'b1;
	localparam logic [7:0] QUANTUM_RESET = 8'd4;

	localparam logic [23:0] WT_MAX = 24'hFFFFFF;

	// configuration register selects (paddr bit 2)
	localparam logic REG_POLICY  = 1'b0;
	localparam logic REG_QUANTUM = 1'b1;

	localparam logic POLICY_FCFS = 1'b0;

	typedef enum logic [1:0] {
		ST_FINISHED  = 2'd0,
		ST_DROP_FULL = 2'd1,
		ST_ZERO_SVC  = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_TICK = 5'b00010,
		S_HEAD = 5'b00100,
		S_DIV  = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

endpackage

[sv/rrjs_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module rrjs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/rrjs_div.sv]
// restoring divider, one quotient bit per cycle
module rrjs_div
	import rrjs_pkg::*;
#(
	parameter int unsigned NW = 24,
	parameter int unsigned DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int unsigned CNW = $clog2(NW + 1);

	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  dvs_q;
	logic [NW-1:0]  quo_q;
	logic [CNW-1:0] cnt_q;
	logic           run_q;
	logic [DW:0]    trial;
	logic           take;

	assign trial = {rem_q, quo_q[NW-1]};
	assign take  = trial >= {1'b0, dvs_q};
	assign done  = run_q && (cnt_q == CNW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNW'(NW);
		end else if (run_q) begin
			cnt_q <= cnt_q - CNW'(1);
			if (cnt_q == CNW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			// a zero divisor always takes, giving an all-ones quotient
			rem_q <= take ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], take};
		end
	end

	assign quotient = quo_q;

endmodule

[sv/round_robin_job_scheduler.sv]
// round-robin job scheduler: ring queue in ram, tick sequencer, apb registers
//
//  port group     dir  transfer when                    content
//  s_t*           in   s_tvalid & s_tready              job arrival and tick request
//  m_t*           out  m_tvalid & m_tready              finished or refused job
//  p* (apb)       in   psel & penable & pwrite & pready policy, quantum
//
// an item without a tick is taken in S_IDLE alone; a tick passes S_TICK and, on a
// non-empty queue, S_HEAD; a finishing tick goes on through S_DIV, where the serial
// divider forms the weighted turnover, and S_EMIT; a refusal goes to S_EMIT.
// the queue ram needs no clearing after reset, only occupied entries are read.
// a result waits in the output register; the next item is taken meanwhile and
// stalls only when it has a new result ready while the old one is still held.
module round_robin_job_scheduler
	import rrjs_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// job_name[7:0], arrival[23:8], service[39:24], advance[40], zero pad
	input  logic [47:0] s_tdata,
	// new_job[0]
	input  logic [0:0]  s_tuser,
	input  logic        s_tvalid,
	output logic        s_tready,
	// done_name[7:0], done_arrival[23:8], done_service[39:24], finish_time[55:40],
	// turnover[71:56], weighted_turnover[95:72]
	output logic [95:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned TW  = TIME_WIDTH;
	localparam int unsigned PW  = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned EW  = 8 + 3 * TW;
	localparam int unsigned QW  = TW + 8;

	// ------------------------------------------------------------ registers
	logic       policy_q;
	logic [7:0] quantum_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= POLICY_RESET;
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_POLICY) begin
				policy_q <= pwdata[0];
			end else begin
				quantum_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_QUANTUM) ? {24'b0, quantum_q} : {31'b0, policy_q};

	// ------------------------------------------------------------ input fields
	logic [7:0]  in_name;
	logic [15:0] in_arr;
	logic [15:0] in_svc;
	logic        in_adv;
	logic        in_new;
	logic [TW+15:0] in_arr_ext;
	logic [TW+15:0] in_svc_ext;

	assign in_name    = s_tdata[7:0];
	assign in_arr     = s_tdata[23:8];
	assign in_svc     = s_tdata[39:24];
	assign in_adv     = s_tdata[40];
	assign in_new     = s_tuser[0];
	assign in_arr_ext = {{TW{1'b0}}, in_arr};
	assign in_svc_ext = {{TW{1'b0}}, in_svc};

	// ------------------------------------------------------------ control state
	state_t         state_q;
	logic [PW-1:0]  head_q;
	logic [PW-1:0]  tail_q;
	logic [CW-1:0]  count_q;
	logic [TW-1:0]  tick_q;
	logic [7:0]     slice_q;

	logic accept;
	logic full;
	logic rej_zero;
	logic rej_full;
	logic admit;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign rej_zero = in_new & (in_svc == 16'd0);
	assign rej_full = in_new & !rej_zero & full;
	assign admit    = accept & in_new & !rej_zero & !full;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// ------------------------------------------------------------ queue ram
	logic          ram_we;
	logic [PW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic          ram_re;
	logic [EW-1:0] ram_rdata;

	// head entry fields, valid in S_HEAD
	logic [7:0]    hd_name;
	logic [TW-1:0] hd_arr;
	logic [TW-1:0] hd_svc;
	logic [TW-1:0] hd_rem;
	logic [TW-1:0] rem_new;
	logic [7:0]    slice_new;
	logic          finish;
	logic          rotate;
	logic [TW-1:0] turn;
	logic [TW+15:0] arr_ext;
	logic [TW+15:0] svc_ext;
	logic [TW+15:0] tick_ext;
	logic [TW+15:0] turn_ext;

	assign hd_rem  = ram_rdata[TW-1:0];
	assign hd_svc  = ram_rdata[2*TW-1:TW];
	assign hd_arr  = ram_rdata[3*TW-1:2*TW];
	assign hd_name = ram_rdata[EW-1:3*TW];

	assign rem_new   = hd_rem - TW'(1);
	assign slice_new = (policy_q == POLICY_FCFS) ? slice_q : slice_q - 8'd1;
	assign finish    = (rem_new == '0);
	assign rotate    = !finish && (policy_q != POLICY_FCFS) && (slice_new == 8'd0);
	assign turn      = tick_q - hd_arr;
	assign arr_ext   = {16'b0, hd_arr};
	assign svc_ext   = {16'b0, hd_svc};
	assign tick_ext  = {16'b0, tick_q};
	assign turn_ext  = {16'b0, turn};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = {in_name, in_arr_ext[TW-1:0], in_svc_ext[TW-1:0], in_svc_ext[TW-1:0]};
		if (admit) begin
			ram_we = 1'b1;
		end else if (state_q == S_HEAD && !finish) begin
			// rotation moves the updated entry to the tail, else write back in place
			ram_we    = 1'b1;
			ram_waddr = rotate ? tail_q : head_q;
			ram_wdata = {ram_rdata[EW-1:TW], rem_new};
		end
	end

	assign ram_re = (state_q == S_TICK) && (count_q != '0);

	rrjs_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------ divider
	logic          div_start;
	logic          div_done;
	logic [QW-1:0] div_quo;

	assign div_start = (state_q == S_HEAD) && finish;

	rrjs_div #(
		.NW (QW),
		.DW (TW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({turn, 8'b0}),
		.divisor  (hd_svc),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ------------------------------------------------------------ sequencer
	logic out_free;

	assign out_free = !m_tvalid | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			tick_q  <= '0;
			slice_q <= QUANTUM_RESET;
		end else begin
			if (cfg_wr && paddr[2] == REG_QUANTUM) begin
				slice_q <= pwdata[7:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (admit) begin
							tail_q  <= ring_next(tail_q);
							count_q <= count_q + CW'(1);
						end
						if (rej_zero || rej_full) begin
							state_q <= S_EMIT;
						end else if (in_adv) begin
							state_q <= S_TICK;
						end
					end
				end
				S_TICK: begin
					tick_q  <= tick_q + TW'(1);
					state_q <= (count_q != '0) ? S_HEAD : S_IDLE;
				end
				S_HEAD: begin
					slice_q <= slice_new;
					if (finish) begin
						head_q  <= ring_next(head_q);
						count_q <= count_q - CW'(1);
						slice_q <= quantum_q;
						state_q <= S_DIV;
					end else begin
						if (rotate) begin
							head_q  <= ring_next(head_q);
							tail_q  <= ring_next(tail_q);
							slice_q <= quantum_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------ result staging
	status_t     res_status_q;
	logic [7:0]  res_name_q;
	logic [15:0] res_arr_q;
	logic [15:0] res_svc_q;
	logic [15:0] res_fin_q;
	logic [15:0] res_turn_q;
	logic        res_svc_zero_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q   <= rej_zero ? ST_ZERO_SVC : ST_DROP_FULL;
			res_name_q     <= in_name;
			res_arr_q      <= in_arr;
			res_svc_q      <= in_svc;
			res_fin_q      <= '0;
			res_turn_q     <= '0;
			res_svc_zero_q <= 1'b0;
		end else if (div_start) begin
			res_status_q   <= ST_FINISHED;
			res_name_q     <= hd_name;
			res_arr_q      <= arr_ext[15:0];
			res_svc_q      <= svc_ext[15:0];
			res_fin_q      <= tick_ext[15:0];
			res_turn_q     <= turn_ext[15:0];
			res_svc_zero_q <= (hd_svc == '0);
		end
	end

	// saturate the quotient to 24 bits
	logic [QW+23:0] quo_ext;
	logic [23:0]    wt;

	assign quo_ext = {24'b0, div_quo};

	always_comb begin
		if (res_status_q != ST_FINISHED) begin
			wt = '0;
		end else if (res_svc_zero_q || quo_ext > {{QW{1'b0}}, WT_MAX}) begin
			wt = WT_MAX;
		end else begin
			wt = quo_ext[23:0];
		end
	end

	// ------------------------------------------------------------ output register
	logic        m_tvalid_q;
	logic [95:0] m_tdata_q;
	logic [1:0]  m_tuser_q;
	logic        load_out;

	assign load_out = (state_q == S_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {wt, res_turn_q, res_fin_q, res_svc_q, res_arr_q, res_name_q};
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[test/sched_checker.sv]
// checker for the job scheduler: predicts results from observed transfers and compares them
`timescale 1ns / 100ps

module sched_checker
	import rrjs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// job_name[7:0], arrival[23:8], service[39:24], advance[40], zero pad
	input  logic [47:0] s_tdata,
	// new_job[0]
	input  logic [0:0]  s_tuser,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// done_name[7:0], done_arrival[23:8], done_service[39:24], finish_time[55:40],
	// turnover[71:56], weighted_turnover[95:72]
	input  logic [95:0] m_tdata,
	// status[1:0]
	input  logic [1:0]  m_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          mismatches,
	output int          outstanding,
	output int          jobs_held
);

	typedef struct packed {
		logic [7:0]  name;
		logic [15:0] arrival;
		logic [15:0] service;
		logic [15:0] remaining;
	} job_t;

	// low 96 bits line up with the m_tdata layout
	typedef struct packed {
		status_t     status;
		logic [23:0] wt;
		logic [15:0] turnover;
		logic [15:0] finish;
		logic [15:0] service;
		logic [15:0] arrival;
		logic [7:0]  name;
	} job_report_t;

	job_t        job_ring [QUEUE_DEPTH_DEF];
	int          ring_head;
	int          ring_tail;
	int          jobs_queued;
	logic [15:0] tick_now;
	logic [7:0]  slice_rem;
	logic [7:0]  cur_quantum;
	logic        cur_policy;
	job_report_t reports_due [$];
	int          err_count;

	task automatic log_mismatch(input string msg);
		err_count++;
		if (err_count <= 40)
			$display("%0t ns  MISMATCH: %s", $time, msg);
	endtask

	// one scheduler step: admission, then an optional tick; returns 1 when a report is due
	function automatic bit run_scheduler(input logic nj, input logic [7:0] nm,
			input logic [15:0] arr, input logic [15:0] svc, input logic adv,
			output job_report_t rep);
		logic [15:0] turn;
		logic [31:0] ratio;
		rep = '0;
		if (nj) begin
			// a refused arrival skips its tick
			if (svc == '0 || jobs_queued >= QUEUE_DEPTH_DEF) begin
				rep.status  = (svc == '0) ? ST_ZERO_SVC : ST_DROP_FULL;
				rep.name    = nm;
				rep.arrival = arr;
				rep.service = svc;
				return 1'b1;
			end
			job_ring[ring_tail] = '{nm, arr, svc, svc};
			ring_tail = (ring_tail + 1) % QUEUE_DEPTH_DEF;
			jobs_queued++;
		end
		if (!adv)
			return 1'b0;
		tick_now = tick_now + 16'd1;
		if (jobs_queued == 0)
			return 1'b0;
		job_ring[ring_head].remaining = job_ring[ring_head].remaining - 16'd1;
		if (cur_policy != POLICY_FCFS)
			slice_rem = slice_rem - 8'd1;
		if (job_ring[ring_head].remaining == '0) begin
			turn  = tick_now - job_ring[ring_head].arrival;
			ratio = {8'h00, turn, 8'h00} / {16'h0000, job_ring[ring_head].service};
			if (ratio > {8'h00, WT_MAX})
				ratio = {8'h00, WT_MAX};
			rep.status   = ST_FINISHED;
			rep.name     = job_ring[ring_head].name;
			rep.arrival  = job_ring[ring_head].arrival;
			rep.service  = job_ring[ring_head].service;
			rep.finish   = tick_now;
			rep.turnover = turn;
			rep.wt       = ratio[23:0];
			ring_head = (ring_head + 1) % QUEUE_DEPTH_DEF;
			jobs_queued--;
			slice_rem = cur_quantum;
			return 1'b1;
		end
		// slice used up: head job moves to the tail
		if (cur_policy != POLICY_FCFS && slice_rem == '0) begin
			job_ring[ring_tail] = job_ring[ring_head];
			ring_head = (ring_head + 1) % QUEUE_DEPTH_DEF;
			ring_tail = (ring_tail + 1) % QUEUE_DEPTH_DEF;
			slice_rem = cur_quantum;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		job_report_t rep;
		job_report_t due;
		logic [31:0] reg_val;
		string       bad;
		if (!arst_n) begin
			ring_head   = 0;
			ring_tail   = 0;
			jobs_queued = 0;
			tick_now    = '0;
			cur_policy  = POLICY_RESET;
			cur_quantum = QUANTUM_RESET;
			slice_rem   = QUANTUM_RESET;
			err_count   = 0;
			reports_due.delete();
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_POLICY) begin
						cur_policy = pwdata[0];
					end else begin
						cur_quantum = pwdata[7:0];
						slice_rem   = pwdata[7:0];
					end
				end else begin
					reg_val = (paddr[2] == REG_POLICY) ? {31'd0, cur_policy} :
						{24'd0, cur_quantum};
					if (prdata !== reg_val)
						log_mismatch($sformatf("register read at %0d: exp %h got %h",
							paddr, reg_val, prdata));
				end
			end
			if (s_tvalid && s_tready) begin
				if (run_scheduler(s_tuser[0], s_tdata[7:0], s_tdata[23:8], s_tdata[39:24],
						s_tdata[40], rep))
					reports_due = {reports_due, rep};
			end
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					log_mismatch($sformatf("result with nothing pending: %h/%h",
						m_tuser, m_tdata));
				end else begin
					due = reports_due.pop_front();
					bad = "";
					if (m_tuser !== due.status)          bad = {bad, " status"};
					if (m_tdata[7:0] !== due.name)       bad = {bad, " name"};
					if (m_tdata[23:8] !== due.arrival)   bad = {bad, " arrival"};
					if (m_tdata[39:24] !== due.service)  bad = {bad, " service"};
					if (m_tdata[55:40] !== due.finish)   bad = {bad, " finish"};
					if (m_tdata[71:56] !== due.turnover) bad = {bad, " turnover"};
					if (m_tdata[95:72] !== due.wt)       bad = {bad, " weighted"};
					if (bad != "")
						log_mismatch($sformatf("wrong%s: exp %h/%h got %h/%h", bad,
							due.status, due[95:0], m_tuser, m_tdata));
				end
			end
		end
		outstanding <= reports_due.size();
		jobs_held   <= jobs_queued;
		mismatches  <= err_count;
	end

endmodule

[test/testbench.sv]
// top of the job scheduler test: clock, reset, stimulus, register setup and verdict
`timescale 1ns / 100ps

module testbench;
	import rrjs_pkg::*;

	localparam logic [2:0] ADDR_POLICY  = {REG_POLICY, 2'b00};
	localparam logic [2:0] ADDR_QUANTUM = {REG_QUANTUM, 2'b00};
	localparam int         PHASES       = 7;
	localparam int         PHASE_ITEMS  = 265;

	logic        clk;
	logic        arst_n;
	// job_name[7:0], arrival[23:8], service[39:24], advance[40], zero pad
	logic [47:0] s_tdata;
	// new_job[0]
	logic [0:0]  s_tuser;
	logic        s_tvalid;
	logic        s_tready;
	// done_name[7:0], done_arrival[23:8], done_service[39:24], finish_time[55:40],
	// turnover[71:56], weighted_turnover[95:72]
	logic [95:0] m_tdata;
	// status[1:0]
	logic [1:0]  m_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          mismatches;
	int          outstanding;
	int          jobs_held;

	logic        calm = 1'b0;
	logic        last_adv;

	round_robin_job_scheduler dut (.*);
	sched_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk)
		m_tready <= calm || ($urandom_range(0, 99) >= 20);

	task automatic send_job_item(input logic nj, input logic [7:0] nm, input logic [15:0] arr,
			input logic [15:0] svc, input logic adv);
		while (!calm && $urandom_range(0, 99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata  <= {7'd0, adv, svc, arr, nm};
		s_tuser  <= nj;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		last_adv = adv;
	endtask

	task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// no report pending, then enough cycles for a silent tick to finish
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_mode(input logic pol, input logic [7:0] quant, input logic no_gaps);
		wait_quiet();
		calm <= no_gaps;
		apb_xfer(1'b1, ADDR_POLICY, {31'd0, pol});
		apb_xfer(1'b1, ADDR_QUANTUM, {24'd0, quant});
		apb_xfer(1'b0, ADDR_POLICY, '0);
		apb_xfer(1'b0, ADDR_QUANTUM, '0);
	endtask

	function automatic logic [15:0] pick_service();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 16'd0;
		if (r < 70)
			return 16'($urandom_range(1, 6));
		if (r < 95)
			return 16'($urandom_range(7, 40));
		return 16'($urandom_range(41, 120));
	endfunction

	initial begin : stimulus
		logic        mode_pol [PHASES];
		logic [7:0]  mode_quant [PHASES];
		logic        nj;
		logic        adv;
		logic [7:0]  nm;
		logic [15:0] arr;
		logic [15:0] svc;
		int          sent;
		int          burst_left;
		int unsigned roll;

		mode_pol   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
		// quantum zero behaves as a 256-tick slice
		mode_quant = '{8'd1, 8'd4, 8'd255, 8'd0, 8'd255, 8'd3, 8'd2};

		arst_n   = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		s_tvalid = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		last_adv = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		apb_xfer(1'b0, ADDR_POLICY, '0);
		apb_xfer(1'b0, ADDR_QUANTUM, '0);

		// tick on an empty queue, zero service refusal, single-tick job
		send_job_item(1'b0, 8'h00, 16'h0000, 16'h0000, 1'b1);
		send_job_item(1'b1, 8'hFF, 16'hFFFF, 16'h0000, 1'b1);
		send_job_item(1'b1, 8'h00, 16'h0000, 16'h0001, 1'b0);
		send_job_item(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
		// arrival after the current tick makes the turnover wrap; job outlasts its slice
		send_job_item(1'b1, 8'hA5, 16'hFFFF, 16'h0006, 1'b0);
		for (int i = 1; i < 16; i++)
			send_job_item(1'b1, 8'(i), 16'(i), 16'(i % 3 + 1), 1'b0);
		// full queue drop, then rotation with the ring full
		send_job_item(1'b1, 8'h5A, 16'h8001, 16'hFFFF, 1'b1);
		repeat (4) send_job_item(1'b0, 8'h00, 16'h0000, 16'h0000, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_mode(mode_pol[ph], mode_quant[ph], ph == 2);
			sent       = 0;
			burst_left = 0;
			while (sent < PHASE_ITEMS) begin
				nm  = 8'($urandom);
				arr = 16'($urandom);
				if (burst_left > 0) begin
					// admit-only run that fills the ring; wide services once it is full
					burst_left--;
					if (jobs_held == QUEUE_DEPTH_DEF && !last_adv)
						svc = 16'($urandom_range(0, 65535));
					else
						svc = pick_service();
					send_job_item(1'b1, nm, arr, svc, 1'b0);
					sent++;
				end else begin
					roll = $urandom_range(0, 99);
					if (roll < 40) begin
						send_job_item(1'b1, nm, arr, pick_service(), 1'b1);
						sent++;
					end else if (roll < 50) begin
						send_job_item(1'b1, nm, arr, pick_service(), 1'b0);
						sent++;
					end else if (roll < 92) begin
						svc = 16'($urandom);
						send_job_item(1'b0, nm, arr, svc, 1'b1);
						sent++;
					end else if (roll < 95) begin
						svc = 16'($urandom);
						send_job_item(1'b0, nm, arr, svc, 1'b0);
					end else begin
						burst_left = $urandom_range(8, 20);
					end
				end
			end
		end

		wait_quiet();
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
